// ===== hdl/ipv4_header_check_and_ttl_forward_defines.svh =====
// assertion macros for the ipv4 header check block
// expects clk_i and rst_ni in the scope of each use
`ifndef IPV4_HEADER_CHECK_AND_TTL_FORWARD_DEFINES_SVH
`define IPV4_HEADER_CHECK_AND_TTL_FORWARD_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define HCK_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hck assertion failed");

// consequence checked in the cycle after the antecedent
`define HCK_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hck assertion failed");

`endif

// ===== hdl/hck_pkg.sv =====
// shared types, constants and a helper function for the ipv4 header check block
// no dependencies
package hck_pkg;

  localparam int unsigned HdrWords = 10;
  localparam int unsigned CntW     = 4;
  localparam logic [3:0]  MinIhl   = 4'd5;

  localparam logic [15:0] RstMinLen  = 16'd20;
  localparam logic [15:0] RstMaxLen  = 16'd1500;
  localparam logic [3:0]  RstVersion = 4'd4;

  localparam logic [CntW-1:0] WordVerIhl  = CntW'(0);
  localparam logic [CntW-1:0] WordLength  = CntW'(1);
  localparam logic [CntW-1:0] WordTtlProt = CntW'(4);
  localparam logic [CntW-1:0] WordCheck   = CntW'(5);
  localparam logic [CntW-1:0] WordDestHi  = CntW'(8);
  localparam logic [CntW-1:0] WordLast    = CntW'(HdrWords - 1);

  typedef enum logic [2:0] {
    STS_FORWARD   = 3'd0,
    STS_SHORT     = 3'd1,
    STS_BAD_CKSUM = 3'd2,
    STS_BAD_VER   = 3'd3,
    STS_BAD_IHL   = 3'd4,
    STS_TOO_LONG  = 3'd5,
    STS_TTL_EXP   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_MIN_LEN = 2'd0,
    CFG_MAX_LEN = 2'd1,
    CFG_VERSION = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] min_len;
    logic [15:0] max_len;
    logic [3:0]  version;
  } cfg_t;

  typedef struct packed {
    logic [19:0] sum;
    logic [15:0] ver_ihl;
    logic [15:0] length;
    logic [15:0] ttl_proto;
    logic [15:0] check;
    logic [31:0] dest;
  } hdr_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] dest_addr;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
    logic [15:0] total_length;
  } result_t;

  // end-around carry fold of a 20-bit sum, two folds always settle it
  function automatic logic [15:0] ones_fold(input logic [19:0] s);
    logic [16:0] a;
    a = {1'b0, s[15:0]} + {13'b0, s[19:16]};
    return a[15:0] + {15'b0, a[16]};
  endfunction

endpackage

// ===== hdl/hck_if.sv =====
// handshake channels of the ipv4 header check block: header words in, verdicts out
// plain logic payloads, no dependencies
interface hck_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_word;
  logic        start_req;

  modport source (output valid, header_word, start_req, input ready);
  modport sink   (input valid, header_word, start_req, output ready);
endinterface

interface hck_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] dest_addr;
  logic [7:0]  new_ttl;
  logic [15:0] new_checksum;
  logic [15:0] total_length;

  modport source (output valid, status, dest_addr, new_ttl, new_checksum, total_length,
                  input ready);
  modport sink   (input valid, status, dest_addr, new_ttl, new_checksum, total_length,
                  output ready);
endinterface

// ===== hdl/hck_verdict.sv =====
// verdict logic: ordered header checks, ttl decrement and incremental checksum
// uses hck_pkg types and the one's-complement fold
module hck_verdict (
  input  hck_pkg::hdr_t    hdr_i,
  input  hck_pkg::cfg_t    cfg_i,
  output hck_pkg::result_t res_o
);

  logic [7:0]  ttl;
  logic [7:0]  ttl_dec;
  logic [15:0] m_new;
  logic [19:0] ck_sum;
  logic [15:0] ck_new;
  hck_pkg::status_e status;

  assign ttl     = hdr_i.ttl_proto[15:8];
  assign ttl_dec = ttl - 8'd1;
  assign m_new   = {ttl_dec, hdr_i.ttl_proto[7:0]};
  // rfc 1624 eqn 3: ~(~hc + ~m + m')
  assign ck_sum  = {4'b0, ~hdr_i.check} + {4'b0, ~hdr_i.ttl_proto} + {4'b0, m_new};
  assign ck_new  = ~hck_pkg::ones_fold(ck_sum);

  always_comb begin
    if (hdr_i.length < cfg_i.min_len) begin
      status = hck_pkg::STS_SHORT;
    end else if (hck_pkg::ones_fold(hdr_i.sum) != 16'hFFFF) begin
      status = hck_pkg::STS_BAD_CKSUM;
    end else if (hdr_i.ver_ihl[15:12] != cfg_i.version) begin
      status = hck_pkg::STS_BAD_VER;
    end else if (hdr_i.ver_ihl[11:8] < hck_pkg::MinIhl) begin
      status = hck_pkg::STS_BAD_IHL;
    end else if (hdr_i.length > cfg_i.max_len) begin
      status = hck_pkg::STS_TOO_LONG;
    end else if (ttl <= 8'd1) begin
      status = hck_pkg::STS_TTL_EXP;
    end else begin
      status = hck_pkg::STS_FORWARD;
    end
  end

  always_comb begin
    res_o.status       = status;
    res_o.total_length = hdr_i.length;
    if (status == hck_pkg::STS_FORWARD) begin
      res_o.dest_addr    = hdr_i.dest;
      res_o.new_ttl      = ttl_dec;
      res_o.new_checksum = ck_new;
    end else begin
      res_o.dest_addr    = '0;
      res_o.new_ttl      = '0;
      res_o.new_checksum = '0;
    end
  end

endmodule

// ===== hdl/ipv4_header_check_and_ttl_forward.sv =====
// top level of the ipv4 header check and ttl forward block
// depends on hck_pkg, hck_if.sv, hck_verdict and the defines header
//
//   channel   dir  handshake          payload
//   hdr_i     in   valid/ready        header_word[15:0], start_req
//   res_o     out  valid/ready        status, dest_addr, new_ttl, new_checksum, total_length
//   cfg       in   cfg_we_i (no wait) cfg_idx_i[1:0], cfg_wdata_i[15:0]
//
// one header word per cycle while hdr_i.ready is high; ten words make one header, one verdict
// the verdict is computed the cycle after the tenth word and then held in the result register
// a new header word is taken while a verdict waits, up to the tenth word of the next header
// counter, pending flag and result valid clear, config takes its defaults on rst_ni (async, low)
`include "ipv4_header_check_and_ttl_forward_defines.svh"

module ipv4_header_check_and_ttl_forward (
  input  logic                clk_i,
  input  logic                rst_ni,
  hck_word_if.sink            hdr_i,
  hck_result_if.source        res_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);

  hck_pkg::cfg_t    cfg_q, cfg_d;
  hck_pkg::hdr_t    hdr_q, hdr_d;
  hck_pkg::result_t verdict;
  hck_pkg::result_t res_q;

  logic [hck_pkg::CntW-1:0] cnt_q, cnt_d, cnt_eff;
  logic pend_q, pend_d;
  logic out_v_q, out_v_d;
  logic out_free;
  logic in_xfer;
  logic last_word;

  // config writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (hck_pkg::cfg_reg_e'(cfg_idx_i))
        hck_pkg::CFG_MIN_LEN: cfg_d.min_len = cfg_wdata_i;
        hck_pkg::CFG_MAX_LEN: cfg_d.max_len = cfg_wdata_i;
        hck_pkg::CFG_VERSION: cfg_d.version = cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign out_free    = !out_v_q || res_o.ready;
  assign hdr_i.ready = !pend_q || out_free;
  assign in_xfer     = hdr_i.valid && hdr_i.ready;
  assign cnt_eff     = hdr_i.start_req ? '0 : cnt_q;
  assign last_word   = (cnt_eff == hck_pkg::WordLast);

  always_comb begin
    cnt_d = cnt_q;
    hdr_d = hdr_q;
    if (in_xfer) begin
      cnt_d     = last_word ? '0 : cnt_eff + hck_pkg::CntW'(1);
      hdr_d.sum = ((cnt_eff == '0) ? 20'd0 : hdr_q.sum) + {4'b0, hdr_i.header_word};
      case (cnt_eff)
        hck_pkg::WordVerIhl:  hdr_d.ver_ihl    = hdr_i.header_word;
        hck_pkg::WordLength:  hdr_d.length     = hdr_i.header_word;
        hck_pkg::WordTtlProt: hdr_d.ttl_proto  = hdr_i.header_word;
        hck_pkg::WordCheck:   hdr_d.check      = hdr_i.header_word;
        hck_pkg::WordDestHi:  hdr_d.dest[31:16] = hdr_i.header_word;
        hck_pkg::WordLast:    hdr_d.dest[15:0]  = hdr_i.header_word;
        default: ;
      endcase
    end
  end

  // pending verdict moves to the result register once that register is free
  assign pend_d  = (pend_q && !out_free) || (in_xfer && last_word);
  assign out_v_d = out_free ? pend_q : out_v_q;

  hck_verdict u_verdict (
    .hdr_i (hdr_q),
    .cfg_i (cfg_q),
    .res_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_len <= hck_pkg::RstMinLen;
      cfg_q.max_len <= hck_pkg::RstMaxLen;
      cfg_q.version <= hck_pkg::RstVersion;
      cnt_q         <= '0;
      pend_q        <= 1'b0;
      out_v_q       <= 1'b0;
    end else begin
      cfg_q   <= cfg_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    if (pend_q && out_free) begin
      res_q <= verdict;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.status       = res_q.status;
  assign res_o.dest_addr    = res_q.dest_addr;
  assign res_o.new_ttl      = res_q.new_ttl;
  assign res_o.new_checksum = res_q.new_checksum;
  assign res_o.total_length = res_q.total_length;

  `HCK_ASSERT(a_cnt_range, cnt_q <= hck_pkg::WordLast)
  `HCK_ASSERT_NEXT(a_last_sets_pend, in_xfer && last_word, pend_q)
  `HCK_ASSERT_NEXT(a_pend_held, pend_q && !out_free, pend_q && out_v_q)
  `HCK_ASSERT_NEXT(a_no_spurious_out, !pend_q && out_free, !out_v_q)

endmodule
